// ----- rtl/button_short_long_press_detector_unit_macros.svh -----
// assertion macros for the button press detector
// used by button_short_long_press_detector_unit; needs clk and rst in scope
`ifndef BUTTON_SHORT_LONG_PRESS_DETECTOR_UNIT_MACROS_SVH
`define BUTTON_SHORT_LONG_PRESS_DETECTOR_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define BSLPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define BSLPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bslpd_pkg.sv -----
// shared types and constants for the button press detector
// no dependencies; used by button_short_long_press_detector_unit
`timescale 1ns / 1ps

package bslpd_pkg;

  // width of the held-time arithmetic (wraps as a signed value)
  localparam int TIME_BITS = 32;
  // width of the timestamp field
  localparam int NOW_W = 32;
  // width of the threshold register
  localparam int THR_W = 8;
  // configuration port widths
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 8;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LEVEL = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd1;

  // register reset values
  localparam logic ACTIVE_LEVEL_RST = 1'b0;
  localparam logic [THR_W-1:0] THRESHOLD_RST = 8'd3;

  // one poll of the button
  typedef struct packed {
    logic             first_sample;
    logic             second_sample;
    logic [NOW_W-1:0] now_seconds;
    logic             idle;
  } poll_t;

  // one result of a poll
  typedef struct packed {
    logic short_press;
    logic long_press;
  } result_t;

endpackage

// ----- rtl/button_short_long_press_detector_unit.sv -----
// Button usage:
//   poll channel (poll_valid / poll_stall / poll) carries one poll per
//   transaction: two pin reads, a seconds timestamp and an idle flag.
//   result channel (result_valid / result_stall / result) returns exactly one
//   transaction per poll with short_press and long_press flags.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   active_level (index 0) and long_press_threshold (index 1); cfg_ready is
//   always high. Write only while no poll is in flight.
// Path: an accepted poll is loaded into the input register; its result is
//   then loaded into the result register.
// Throughput: one poll per cycle when not stalled; the press state (last level,
//   press start, long mark) updates in the same cycle that the result is formed.
// Reset (rst, synchronous): pipeline empty, active_level 0, threshold 3,
//   last level 1, press start 0, long mark clear.
// Stall: while result_stall holds a waiting result, the input register keeps
//   its poll and poll_stall rises once that register is also full.
`timescale 1ns / 1ps
`include "button_short_long_press_detector_unit_macros.svh"

module button_short_long_press_detector_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                poll_valid,
  output logic                                poll_stall,
  input  bslpd_pkg::poll_t                    poll,
  output logic                                result_valid,
  input  logic                                result_stall,
  output bslpd_pkg::result_t                  result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bslpd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bslpd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // configuration registers
  logic                        active_level;
  logic [bslpd_pkg::THR_W-1:0] threshold;

  // input register
  logic             s1_valid;
  bslpd_pkg::poll_t s1;

  // press state
  logic                        last_level;
  logic [bslpd_pkg::NOW_W-1:0] press_start;
  logic                        long_reported;

  // combinational
  logic                            out_free;
  logic                            s1_adv;
  logic                            act;
  logic                            inact;
  logic                            first_act;
  logic                            unconfirmed;
  logic                            level;
  logic                            press_edge;
  logic                            release_edge;
  logic                            holding;
  logic [bslpd_pkg::TIME_BITS-1:0] held;
  logic [bslpd_pkg::TIME_BITS-1:0] thr_ext;
  logic                            held_below;
  logic                            held_above;
  logic                            short_ev;
  logic                            long_ev;
  logic                            last_level_next;
  logic [bslpd_pkg::NOW_W-1:0]     press_start_next;
  logic                            long_reported_next;
  bslpd_pkg::result_t              result_next;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_level <= bslpd_pkg::ACTIVE_LEVEL_RST;
      threshold    <= bslpd_pkg::THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bslpd_pkg::REG_ACTIVE_LEVEL: active_level <= cfg_data[0];
        bslpd_pkg::REG_THRESHOLD:    threshold <= cfg_data[bslpd_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake between the two register stages
  assign out_free   = !result_valid || !result_stall;
  assign s1_adv     = s1_valid && out_free;
  assign poll_stall = s1_valid && !out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!poll_stall) begin
      s1_valid <= poll_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll_valid && !poll_stall) begin
      s1 <= poll;
    end
  end

  // level qualification: an active read needs a confirming second read
  assign act         = active_level;
  assign inact       = ~active_level;
  assign first_act   = (s1.first_sample == act);
  assign unconfirmed = first_act && (s1.second_sample != act);
  assign level       = first_act ? act : inact;

  // transitions against the last qualified level
  assign press_edge   = !unconfirmed && (last_level == inact) && (level == act);
  assign release_edge = !unconfirmed && (last_level == act) && (level == inact);
  assign holding      = !unconfirmed && (last_level == act) && (level == act);

  // wrapped held time, read as signed
  assign held = bslpd_pkg::TIME_BITS'(64'(s1.now_seconds) - 64'(press_start));
  assign thr_ext = bslpd_pkg::TIME_BITS'(threshold);
  assign held_below = held[bslpd_pkg::TIME_BITS-1] || (held < thr_ext);
  assign held_above = !held[bslpd_pkg::TIME_BITS-1] && (held > thr_ext);

  // events and next state
  assign short_ev = release_edge && held_below;
  assign long_ev  = holding && held_above && !long_reported;

  assign last_level_next    = unconfirmed ? last_level : level;
  assign press_start_next   = press_edge ? s1.now_seconds : press_start;
  assign long_reported_next = release_edge ? 1'b0 : (long_ev ? 1'b1 : long_reported);

  assign result_next.short_press = short_ev && s1.idle;
  assign result_next.long_press  = long_ev && s1.idle;

  // press state update
  always_ff @(posedge clk) begin
    if (rst) begin
      last_level    <= 1'b1;
      press_start   <= '0;
      long_reported <= 1'b0;
    end else if (s1_adv) begin
      last_level    <= last_level_next;
      press_start   <= press_start_next;
      long_reported <= long_reported_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result <= result_next;
    end
  end

  // checks
  `BSLPD_ASSERT_NOW(a_one_event, result_valid, !(&result), "short and long press in one result")
  `BSLPD_ASSERT_NEXT(a_long_marked, s1_adv && long_ev, long_reported, "long press not marked")
  `BSLPD_ASSERT_NEXT(a_s1_held, s1_valid && !out_free, s1_valid, "stalled poll dropped")
  `BSLPD_ASSERT_NEXT(a_unconf_keeps, s1_adv && unconfirmed, $stable(last_level), "level changed")

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for button_short_long_press_detector_unit
// depends on bslpd_pkg and the unit; drives polls and register writes, predicts each result
`timescale 1ns / 1ps

module tb;
  import bslpd_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 3000;
  localparam int N_PHASES = 6;
  localparam int PHASE_POLLS = 190;
  localparam int N_ROWS = 22;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic poll_valid = 1'b0;
  logic poll_stall;
  poll_t poll = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  button_short_long_press_detector_unit dut (
    .clk(clk),
    .rst(rst),
    .poll_valid(poll_valid),
    .poll_stall(poll_stall),
    .poll(poll),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state and register copies
  logic pressed_lvl = ACTIVE_LEVEL_RST;
  logic [THR_W-1:0] hold_thr = THRESHOLD_RST;
  logic prev_lvl = 1'b1;
  logic [NOW_W-1:0] press_t0 = '0;
  logic long_done = 1'b0;

  result_t press_flags_q[$];
  int errors = 0;
  logic no_idle = 1'b0;
  bit sending = 1'b0;

  // wrapped signed hold time against the threshold: -1 below, 0 equal, 1 above
  function automatic int held_cmp(logic [NOW_W-1:0] now);
    logic [TIME_BITS-1:0] held;
    held = TIME_BITS'(now - press_t0);
    if (held[TIME_BITS-1]) return -1;
    if (held < TIME_BITS'(hold_thr)) return -1;
    if (held == TIME_BITS'(hold_thr)) return 0;
    return 1;
  endfunction

  // expected flags for one poll; advances the predictor state
  function automatic result_t predict_press(poll_t p);
    result_t r;
    logic lvl;
    logic short_ev;
    logic long_ev;
    r = '0;
    short_ev = 1'b0;
    long_ev = 1'b0;
    // unconfirmed active read leaves everything alone
    if (p.first_sample == pressed_lvl && p.second_sample != pressed_lvl) return r;
    lvl = (p.first_sample == pressed_lvl) ? pressed_lvl : ~pressed_lvl;
    if (prev_lvl != pressed_lvl && lvl == pressed_lvl) begin
      press_t0 = p.now_seconds;
    end else if (prev_lvl == pressed_lvl && lvl != pressed_lvl) begin
      if (held_cmp(p.now_seconds) < 0) short_ev = 1'b1;
      long_done = 1'b0;
    end else if (prev_lvl == pressed_lvl && lvl == pressed_lvl) begin
      if (held_cmp(p.now_seconds) > 0 && !long_done) begin
        long_ev = 1'b1;
        long_done = 1'b1;
      end
    end
    prev_lvl = lvl;
    if (p.idle) begin
      r.short_press = short_ev;
      r.long_press = long_ev;
    end
    return r;
  endfunction

  // present one poll and hold it until the transaction completes
  task automatic send_poll(poll_t p, bit typed, result_t want);
    result_t exp_flags;
    poll <= p;
    poll_valid <= 1'b1;
    sending = 1'b1;
    do @(posedge clk); while (!(poll_valid && !poll_stall));
    exp_flags = predict_press(p);
    if (typed) exp_flags = want;
    press_flags_q.push_back(exp_flags);
  endtask

  task automatic drop_valid();
    if (sending) begin
      poll_valid <= 1'b0;
      sending = 1'b0;
    end
  endtask

  // register write, only once every result is back
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drop_valid();
    while (press_flags_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      REG_ACTIVE_LEVEL: pressed_lvl = data[0];
      REG_THRESHOLD:    hold_thr = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // result checking and receiver stall bursts
  int stall_left = 0;
  always @(posedge clk) begin
    result_t exp_flags;
    logic next_stall;
    if (!rst && result_valid && !result_stall) begin
      if (press_flags_q.size() == 0) begin
        $error("result transaction with no expectation waiting");
        errors++;
      end else begin
        exp_flags = press_flags_q.pop_front();
        if (result.short_press !== exp_flags.short_press) begin
          $error("short_press: expected %0b, got %0b", exp_flags.short_press,
                 result.short_press);
          errors++;
        end
        if (result.long_press !== exp_flags.long_press) begin
          $error("long_press: expected %0b, got %0b", exp_flags.long_press,
                 result.long_press);
          errors++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      next_stall = 1'b1;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 14);
      next_stall = 1'b1;
    end else begin
      next_stall = 1'b0;
    end
    result_stall <= next_stall;
  end

  // watchdog on cycles with no transaction anywhere
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (poll_valid && !poll_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // directed polls, starting from reset state (active low, threshold 3)
  typedef struct {
    logic first;
    logic second;
    logic [NOW_W-1:0] now;
    logic idle;
    bit typed;
    logic want_short;
    logic want_long;
  } row_t;

  row_t dir_rows[N_ROWS];

  initial begin
    poll_t p;
    result_t want;
    logic [CFG_INDEX_W-1:0] unused_idx;
    logic act_tab[N_PHASES];
    logic [THR_W-1:0] thr_tab[N_PHASES];
    logic [NOW_W-1:0] clock_s;
    int step_max;
    logic held_on;

    // released, unconfirmed press, press and hold around the threshold
    dir_rows[0]  = '{1'b1, 1'b0, 32'd0, 1'b1, 1'b1, 1'b0, 1'b0};
    dir_rows[1]  = '{1'b0, 1'b1, 32'd10, 1'b1, 1'b1, 1'b0, 1'b0};
    dir_rows[2]  = '{1'b0, 1'b0, 32'd100, 1'b1, 1'b0, 1'b0, 1'b0};
    dir_rows[3]  = '{1'b0, 1'b0, 32'd102, 1'b1, 1'b0, 1'b0, 1'b0};
    dir_rows[4]  = '{1'b0, 1'b0, 32'd103, 1'b1, 1'b0, 1'b0, 1'b0};
    dir_rows[5]  = '{1'b0, 1'b0, 32'd104, 1'b1, 1'b1, 1'b0, 1'b1};
    dir_rows[6]  = '{1'b0, 1'b0, 32'd200, 1'b1, 1'b0, 1'b0, 1'b0};
    dir_rows[7]  = '{1'b1, 1'b1, 32'd201, 1'b1, 1'b0, 1'b0, 1'b0};
    // short press, release at exactly threshold, short press while busy
    dir_rows[8]  = '{1'b0, 1'b0, 32'd300, 1'b1, 1'b0, 1'b0, 1'b0};
    dir_rows[9]  = '{1'b1, 1'b1, 32'd301, 1'b1, 1'b1, 1'b1, 1'b0};
    dir_rows[10] = '{1'b0, 1'b0, 32'd400, 1'b1, 1'b0, 1'b0, 1'b0};
    dir_rows[11] = '{1'b1, 1'b0, 32'd403, 1'b1, 1'b1, 1'b0, 1'b0};
    dir_rows[12] = '{1'b0, 1'b0, 32'd500, 1'b0, 1'b0, 1'b0, 1'b0};
    dir_rows[13] = '{1'b1, 1'b1, 32'd501, 1'b0, 1'b0, 1'b0, 1'b0};
    // hold across timestamp wrap, long event lost while busy
    dir_rows[14] = '{1'b0, 1'b0, 32'hFFFF_FFFE, 1'b1, 1'b0, 1'b0, 1'b0};
    dir_rows[15] = '{1'b0, 1'b0, 32'h0000_0002, 1'b0, 1'b1, 1'b0, 1'b0};
    dir_rows[16] = '{1'b0, 1'b0, 32'h0000_0003, 1'b1, 1'b0, 1'b0, 1'b0};
    dir_rows[17] = '{1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 1'b0};
    dir_rows[18] = '{1'b1, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b0};
    // negative hold time: never long, short on release
    dir_rows[19] = '{1'b0, 1'b0, 32'd1000, 1'b1, 1'b0, 1'b0, 1'b0};
    dir_rows[20] = '{1'b0, 1'b0, 32'd0, 1'b1, 1'b0, 1'b0, 1'b0};
    dir_rows[21] = '{1'b1, 1'b1, 32'd5, 1'b1, 1'b1, 1'b1, 1'b0};

    act_tab = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    thr_tab = '{8'd3, 8'd0, 8'd255, 8'd1, 8'd7, 8'd3};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i]) begin
      p.first_sample = dir_rows[i].first;
      p.second_sample = dir_rows[i].second;
      p.now_seconds = dir_rows[i].now;
      p.idle = dir_rows[i].idle;
      want.short_press = dir_rows[i].want_short;
      want.long_press = dir_rows[i].want_long;
      send_poll(p, dir_rows[i].typed, want);
      if ($urandom_range(0, 5) == 0) begin
        drop_valid();
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end

    // random phases, one register setting each
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_reg(REG_ACTIVE_LEVEL, {7'($urandom), act_tab[ph]});
      write_reg(REG_THRESHOLD, thr_tab[ph]);
      if (ph == 2) begin
        unused_idx = REG_SPARE - 2'($urandom_range(0, 1));
        write_reg(unused_idx, 8'($urandom));
      end
      if (ph == N_PHASES - 1) no_idle <= 1'b1;
      step_max = hold_thr / 2 + 2;
      clock_s = $urandom;
      held_on = 1'b0;
      for (int i = 0; i < PHASE_POLLS; i++) begin
        // mostly monotonic time near the threshold, with rare jumps
        if ($urandom_range(0, 39) == 0) clock_s = $urandom;
        else clock_s = clock_s + NOW_W'($urandom_range(0, step_max));
        if ($urandom_range(0, 3) == 0) held_on = ~held_on;
        if ($urandom_range(0, 9) == 0) begin
          // noise
          p.first_sample = 1'($urandom);
          p.second_sample = 1'($urandom);
        end else if (held_on) begin
          p.first_sample = pressed_lvl;
          p.second_sample = ($urandom_range(0, 9) == 0) ? ~pressed_lvl : pressed_lvl;
        end else begin
          p.first_sample = ~pressed_lvl;
          p.second_sample = 1'($urandom);
        end
        p.now_seconds = clock_s;
        p.idle = ($urandom_range(0, 4) != 0);
        send_poll(p, 1'b0, '0);
        if (!no_idle && $urandom_range(0, 5) == 0) begin
          drop_valid();
          repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        // hold the sender until the pipeline drains
        if (ph == 1 && i == PHASE_POLLS / 2) begin
          drop_valid();
          while (press_flags_q.size() != 0) @(posedge clk);
        end
      end
    end

    // drain and finish
    drop_valid();
    while (press_flags_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (press_flags_q.size() != 0) begin
      $error("expected result transactions left over: %0d", press_flags_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
